>>> rtl/max_pool_grad_scatter_add_unit_defines.svh
// Assertion macros shared by the max-pool gradient scatter-add RTL.
`ifndef MAX_POOL_GRAD_SCATTER_ADD_UNIT_DEFINES_SVH
`define MAX_POOL_GRAD_SCATTER_ADD_UNIT_DEFINES_SVH

// Plain property check on clk, disabled while reset is asserted.
`define MPGSA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Implication check built on the plain form.
`define MPGSA_ASSERT_IMP(label, ante, cons, msg) \
	`MPGSA_ASSERT(label, (ante) |-> (cons), msg)

`endif

>>> rtl/mpgsa_pkg.sv
// Package with shared types and constants of the max-pool gradient scatter-add unit.
package mpgsa_pkg;

	// Fixed field widths of the request and response channels.
	localparam int unsigned POS_W        = 16;
	localparam int unsigned GRAD_W       = 32;
	localparam int unsigned PLANE_SIZE_W = 13;
	localparam int unsigned CMP_W        = POS_W + 1;

	// Plane size register value after reset.
	localparam logic [PLANE_SIZE_W-1:0] PLANE_SIZE_RESET = 13'd4096;

	// Command codes.
	localparam logic CMD_ACCUM = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// Controller states: clearing pass after reset, then normal operation.
	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} state_t;

endpackage

>>> rtl/max_pool_grad_scatter_add_unit.sv
// Top level of the max-pool gradient scatter-add unit.
//
// Usage: each request carries a command, a position and a gradient. An
// accumulate request adds the gradient to the plane entry at the position; a
// read request returns the entry and clears it. Every request gives exactly one
// response with a value and an error flag; error is set, value is zero and the
// store is untouched unless the position is below both the plane size and PLANE_DEPTH.
// Both channels use valid and stall; a request moves when valid is high and
// stall is low. The plane size register is to be written with cfg_we only while
// idle; the block itself does not enforce this. One request is taken every
// cycle while the output is not stalled and no clearing pass runs: the RAM read
// is issued at acceptance, the sum is written back and the response registered
// when the request leaves the read stage, and a holding register of the last
// write forwards data to a request that hits the same entry back to back. After
// reset the block runs a clearing pass, one RAM entry per cycle, and holds in_stall high during it.
// When the receiver stalls, the response waits in the output register, the
// request in the read stage waits behind it, and in_stall rises.
`include "max_pool_grad_scatter_add_unit_defines.svh"

module max_pool_grad_scatter_add_unit #(
	parameter int unsigned PLANE_DEPTH = 4096,
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [mpgsa_pkg::PLANE_SIZE_W-1:0]     cfg_wdata,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   command,
	input  logic [mpgsa_pkg::POS_W-1:0]            position,
	input  logic signed [mpgsa_pkg::GRAD_W-1:0]    gradient,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [mpgsa_pkg::GRAD_W-1:0]    value,
	output logic                                   error
);

	localparam int unsigned AW = $clog2(PLANE_DEPTH);
	localparam int unsigned VW = VALUE_WIDTH;

	// Configuration and controller state.
	logic [mpgsa_pkg::PLANE_SIZE_W-1:0] plane_size_q;
	mpgsa_pkg::state_t                  state_q;
	mpgsa_pkg::state_t                  state_d;
	logic [AW-1:0]                      clr_cnt_q;
	logic                               clr_active;
	logic                               clr_last;

	// Read stage.
	logic                   valid_s1;
	logic                   cmd_s1;
	logic [AW-1:0]          addr_s1;
	logic [VW-1:0]          grad_s1;
	logic                   err_s1;
	logic                   adv_s1;

	// Forwarding register of the most recent write.
	logic                   fwd_valid_q;
	logic [AW-1:0]          fwd_addr_q;
	logic [VW-1:0]          fwd_data_q;

	// Output register.
	logic                   out_valid_q;
	logic [mpgsa_pkg::GRAD_W-1:0] value_q;
	logic                   error_q;

	// Datapath signals.
	logic                               in_acc;
	logic [mpgsa_pkg::CMP_W-1:0]        pos_ext;
	logic                               err_in;
	logic signed [63:0]                 grad_wide;
	logic [VW-1:0]                      rd_data;
	logic signed [VW-1:0]               cur;
	logic [63:0]                        cur_wide;
	logic [VW-1:0]                      new_val;
	logic                               ram_we;
	logic [AW-1:0]                      ram_waddr;
	logic [VW-1:0]                      ram_wdata;

	// Plane size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_size_q <= mpgsa_pkg::PLANE_SIZE_RESET;
		end else if (cfg_we) begin
			plane_size_q <= cfg_wdata;
		end
	end

	// Controller state register and clearing counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mpgsa_pkg::ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (clr_active) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
		end
	end

	// Next state: leave the clearing pass after the last entry is zeroed.
	always_comb begin
		state_d    = state_q;
		clr_active = 1'b0;
		clr_last   = (clr_cnt_q == AW'(PLANE_DEPTH - 1));
		case (state_q)
			mpgsa_pkg::ST_CLEAR: begin
				clr_active = 1'b1;
				if (clr_last) begin
					state_d = mpgsa_pkg::ST_RUN;
				end
			end
			mpgsa_pkg::ST_RUN: begin
				state_d = mpgsa_pkg::ST_RUN;
			end
			default: begin
				state_d = mpgsa_pkg::ST_CLEAR;
			end
		endcase
	end

	// Handshake: the read stage moves on unless the output register is held.
	assign adv_s1   = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = clr_active || (valid_s1 && !adv_s1);
	assign in_acc   = in_valid && !in_stall;

	// Range check against the plane size, saturated to the store depth.
	assign pos_ext = mpgsa_pkg::CMP_W'(position);
	assign err_in  = (pos_ext >= mpgsa_pkg::CMP_W'(plane_size_q)) ||
	                 (pos_ext >= mpgsa_pkg::CMP_W'(PLANE_DEPTH));
	assign grad_wide = 64'(gradient);

	// Read stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Read stage payload, captured with the RAM read.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1  <= command;
			addr_s1 <= position[AW-1:0];
			grad_s1 <= grad_wide[VW-1:0];
			err_s1  <= err_in;
		end
	end

	// Entry value, taking the last write when it hit the same entry.
	assign cur      = (fwd_valid_q && fwd_addr_q == addr_s1) ? fwd_data_q : rd_data;
	assign cur_wide = 64'(cur);
	assign new_val  = (cmd_s1 == mpgsa_pkg::CMD_READ) ? '0 : VW'(cur + grad_s1);

	// RAM write: zero fill during clearing, otherwise the update of the read stage.
	assign ram_we    = clr_active || (adv_s1 && !err_s1);
	assign ram_waddr = clr_active ? clr_cnt_q : addr_s1;
	assign ram_wdata = clr_active ? '0 : new_val;

	mpgsa_ram #(
		.WIDTH (VW),
		.DEPTH (PLANE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (in_acc),
		.raddr (position[AW-1:0]),
		.rdata (rd_data)
	);

	// Forwarding valid flag; the clearing pass invalidates it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (clr_active) begin
			fwd_valid_q <= 1'b0;
		end else if (ram_we) begin
			fwd_valid_q <= 1'b1;
		end
	end

	// Forwarding payload follows every write of the read stage.
	always_ff @(posedge clk) begin
		if (ram_we && !clr_active) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= new_val;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload: entry on a good read, zero otherwise.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			value_q <= (cmd_s1 == mpgsa_pkg::CMD_READ && !err_s1) ?
			           cur_wide[mpgsa_pkg::GRAD_W-1:0] : '0;
			error_q <= err_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign error     = error_q;

	// No request is taken while the store is being cleared.
	`MPGSA_ASSERT_IMP(a_no_accept_in_clear, state_q == mpgsa_pkg::ST_CLEAR, !in_acc && !valid_s1, "request taken during clearing pass")
	// The clearing pass ends only after the last entry.
	`MPGSA_ASSERT_IMP(a_clear_complete, state_q == mpgsa_pkg::ST_RUN && $past(state_q) == mpgsa_pkg::ST_CLEAR, $past(clr_cnt_q) == AW'(PLANE_DEPTH - 1), "clearing pass ended early")
	// A completed read leaves a zero entry behind in the forwarding register.
	`MPGSA_ASSERT_IMP(a_read_clears, adv_s1 && cmd_s1 == mpgsa_pkg::CMD_READ && !err_s1, ##1 (fwd_valid_q && fwd_data_q == '0), "read did not clear the entry")
	// An error response never carries a value.
	`MPGSA_ASSERT_IMP(a_error_zero, out_valid_q && error_q, value_q == '0, "error response with nonzero value")

endmodule

>>> rtl/mpgsa_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module mpgsa_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port, and read port returning the contents before a same-edge write.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
